// ===== design/utda_pkg.sv =====
// ----------------------------------------------------------------------------
// utda_pkg
// Shared types and constants for the unsigned-to-decimal ASCII converter.
// ----------------------------------------------------------------------------
package utda_pkg;

    localparam int NUMBER_W           = 64;
    localparam int DEFAULT_VALUE_BITS = 64;
    localparam int CHAR_W             = 6;
    localparam int RUN_W              = 5;
    localparam int DIGIT_W            = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;

    // operation applied to all digit cells at once
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_BIT,
        CELL_DIGIT
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_STRIP,
        ST_EMIT
    } state_t;

endpackage

// ===== design/utda_digit_cell.sv =====
// ----------------------------------------------------------------------------
// utda_digit_cell
// One BCD digit of the conversion chain: add-3 adjust and bit shift during
// conversion, whole-digit shift toward the top during output.
// ----------------------------------------------------------------------------
module utda_digit_cell
    import utda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_op_t           op,
    input  logic               bit_in,
    input  logic [DIGIT_W-1:0] digit_in,
    output logic               bit_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adjusted;

    // a digit of five or more overflows when doubled
    assign adjusted = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out  = adjusted[DIGIT_W-1];
    assign digit    = digit_reg;

    always_comb
    begin
        case (op)
            CELL_HOLD:  digit_next = digit_reg;
            CELL_CLEAR: digit_next = '0;
            CELL_BIT:   digit_next = {adjusted[DIGIT_W-2:0], bit_in};
            CELL_DIGIT: digit_next = digit_in;
            default:    digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== design/unsigned_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii_top
// Converts an unsigned number to decimal ASCII text, one character per strobe.
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low; only its low
// VALUE_BITS bits count. The block shifts the number one bit a cycle into a
// row of BCD digit cells, then drops leading zero digits one a cycle, then
// sends the digits most significant first and a trailing space flagged by
// last_char, one character a cycle on strobe. Every character carries
// run_length, the digit count plus one. busy stays high while a number is
// converted and sent, so no new number is taken before the last is done.
// Results cannot be held off: each character is on the ports for one cycle
// only and must be taken when strobe is high.
module unsigned_to_decimal_ascii_top
    import utda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUMBER_W-1:0] number,
    output logic                busy,
    output logic                strobe,
    output logic [CHAR_W-1:0]   char_code,
    output logic                last_char,
    output logic [RUN_W-1:0]    run_length
);

    // floor(bits * log10(2)) + 1
    localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BIT_CW     = $clog2(VALUE_BITS);

    state_t                state_reg,  state_next;
    logic [VALUE_BITS-1:0] num_reg,    num_next;
    logic [BIT_CW-1:0]     bitcnt_reg, bitcnt_next;
    logic [RUN_W-1:0]      cnt_reg,    cnt_next;
    logic [RUN_W-1:0]      rem_reg,    rem_next;
    logic                  strobe_reg, strobe_next;
    logic [CHAR_W-1:0]     char_reg,   char_next;
    logic                  last_reg,   last_next;
    logic [RUN_W-1:0]      run_reg,    run_next;
    cell_op_t              op;

    logic [DIGIT_W-1:0]    digit_w [NUM_DIGITS];
    logic                  carry_w [NUM_DIGITS];
    logic [DIGIT_W-1:0]    top_digit;

    assign top_digit = digit_w[NUM_DIGITS-1];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_low
                utda_digit_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .op       (op),
                    .bit_in   (num_reg[VALUE_BITS-1]),
                    .digit_in ('0),
                    .bit_out  (carry_w[g]),
                    .digit    (digit_w[g])
                );
            end
            else
            begin : g_up
                utda_digit_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .op       (op),
                    .bit_in   (carry_w[g-1]),
                    .digit_in (digit_w[g-1]),
                    .bit_out  (carry_w[g]),
                    .digit    (digit_w[g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        num_next    = num_reg;
        bitcnt_next = bitcnt_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        run_next    = run_reg;
        op          = CELL_HOLD;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    num_next    = number[VALUE_BITS-1:0];
                    bitcnt_next = BIT_CW'(VALUE_BITS - 1);
                    op          = CELL_CLEAR;
                    state_next  = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                op          = CELL_BIT;
                num_next    = {num_reg[VALUE_BITS-2:0], 1'b0};
                bitcnt_next = bitcnt_reg - 1'b1;
                if (bitcnt_reg == '0)
                begin
                    cnt_next   = RUN_W'(NUM_DIGITS);
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                // drop leading zeros but keep at least one digit
                if (top_digit == '0 && cnt_reg > 5'd1)
                begin
                    op       = CELL_DIGIT;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    rem_next   = cnt_reg;
                    run_next   = cnt_reg + 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                if (rem_reg != '0)
                begin
                    op        = CELL_DIGIT;
                    char_next = CHAR_ZERO + {2'b00, top_digit};
                    last_next = 1'b0;
                    rem_next  = rem_reg - 1'b1;
                end
                else
                begin
                    char_next  = CHAR_SPACE;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        bitcnt_reg <= bitcnt_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
        run_reg    <= run_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign char_code  = char_reg;
    assign last_char  = last_reg;
    assign run_length = run_reg;

endmodule

// ===== tb/utda_checker.sv =====
// ----------------------------------------------------------------------------
// utda_checker
// Scoreboard for the unsigned-to-decimal ASCII converter.
// ----------------------------------------------------------------------------
// Watches the command port and the character port. Every number taken is
// turned into its expected character run (decimal digits, most significant
// first, then a trailing space flagged as last). Each strobed character is
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module utda_checker
    import utda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUMBER_W-1:0] number,
    input  logic                busy,
    input  logic                strobe,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic                last_char,
    input  logic [RUN_W-1:0]    run_length,
    output int                  fail_count,
    output int                  pending,
    output int                  numbers_seen,
    output int                  chars_seen,
    output logic [31:0]         lengths_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIGITS = 20;
    localparam int MAX_PRINTS = 30;
    localparam logic [NUMBER_W-1:0] VALUE_MASK =
        (VALUE_BITS >= NUMBER_W) ? {NUMBER_W{1'b1}}
                                 : ((NUMBER_W'(1) << VALUE_BITS) - NUMBER_W'(1));

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
        logic [RUN_W-1:0]  run_length;
    } char_word_t;

    char_word_t expected_chars[$];

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        numbers_seen = 0;
        chars_seen   = 0;
        lengths_seen = '0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < MAX_PRINTS)
            $display("%0t ns: %s mismatch on character %0d: got %0d, want %0d",
                     $time, what, chars_seen, got, want);
        fail_count++;
    endtask

    // digits of the masked value, most significant first, then the space
    task automatic queue_decimal_text(input logic [NUMBER_W-1:0] raw);
        logic [NUMBER_W-1:0] value;
        logic [DIGIT_W-1:0]  digits [MAX_DIGITS];
        int                  count;
        char_word_t          word;
        value = raw & VALUE_MASK;
        count = 0;
        do
        begin
            digits[count] = DIGIT_W'(value % 10);
            value         = value / 10;
            count++;
        end
        while (value != 0);
        for (int k = count - 1; k >= 0; k--)
        begin
            word.char_code  = CHAR_ZERO + CHAR_W'(digits[k]);
            word.last_char  = 1'b0;
            word.run_length = RUN_W'(count + 1);
            expected_chars.push_back(word);
        end
        word.char_code  = CHAR_SPACE;
        word.last_char  = 1'b1;
        word.run_length = RUN_W'(count + 1);
        expected_chars.push_back(word);
    endtask

    always @(posedge clk)
    begin : watch
        char_word_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                queue_decimal_text(number);
                numbers_seen++;
            end
            if (strobe)
            begin
                chars_seen++;
                if (expected_chars.size() == 0)
                begin
                    if (fail_count < MAX_PRINTS)
                        $display("%0t ns: character %0d with no number pending",
                                 $time, char_code);
                    fail_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_code !== want.char_code)
                        report_mismatch("char_code", char_code, want.char_code);
                    if (last_char !== want.last_char)
                        report_mismatch("last_char", last_char, want.last_char);
                    if (run_length !== want.run_length)
                        report_mismatch("run_length", run_length, want.run_length);
                    lengths_seen[want.run_length] = 1'b1;
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

// ===== tb/tb_unsigned_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// tb_unsigned_to_decimal_ascii_top
// Testbench for the unsigned-to-decimal ASCII converter.
// ----------------------------------------------------------------------------
// Sends a directed set of corner numbers (zero, digit-count boundaries,
// 32-bit and 64-bit limits, bit patterns), then random numbers drawn from
// several shapes: full width, random bit length, around powers of ten,
// small, near the top and sparse. Gaps between commands are random with
// back-to-back stretches. The checker predicts and compares every character.
// ----------------------------------------------------------------------------
module tb_unsigned_to_decimal_ascii_top
    import utda_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS     = DEFAULT_VALUE_BITS;
    localparam int RANDOM_NUMBERS = 260;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 120;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic [NUMBER_W-1:0] number;
    logic                busy;
    logic                strobe;
    logic [CHAR_W-1:0]   char_code;
    logic                last_char;
    logic [RUN_W-1:0]    run_length;

    int                  fail_count;
    int                  pending;
    int                  numbers_seen;
    int                  chars_seen;
    logic [31:0]         lengths_seen;

    logic                taken;
    int                  stall_cycles;
    int                  burst_left;

    unsigned_to_decimal_ascii_top #(.VALUE_BITS(VALUE_BITS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .number     (number),
        .busy       (busy),
        .strobe     (strobe),
        .char_code  (char_code),
        .last_char  (last_char),
        .run_length (run_length)
    );

    utda_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .number       (number),
        .busy         (busy),
        .strobe       (strobe),
        .char_code    (char_code),
        .last_char    (last_char),
        .run_length   (run_length),
        .fail_count   (fail_count),
        .pending      (pending),
        .numbers_seen (numbers_seen),
        .chars_seen   (chars_seen),
        .lengths_seen (lengths_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // command acceptance seen at the edge, read back at the next falling edge; also a stall watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken        <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            taken <= start && !busy;
            if ((start && !busy) || strobe)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [NUMBER_W-1:0] power_of_ten(input int k);
        logic [NUMBER_W-1:0] p;
        p = 1;
        for (int i = 0; i < k; i++)
            p = p * 10;
        return p;
    endfunction

    function automatic logic [NUMBER_W-1:0] random_number();
        logic [NUMBER_W-1:0] full;
        int                  width;
        int                  shape;
        full  = {$urandom, $urandom};
        shape = $urandom_range(0, 9);
        case (shape)
            0, 1, 2: return full;
            3, 4:
            begin
                width = $urandom_range(1, NUMBER_W);
                return full & ({NUMBER_W{1'b1}} >> (NUMBER_W - width));
            end
            5, 6: return power_of_ten($urandom_range(0, 19)) + $urandom_range(0, 4) - 2;
            7:    return NUMBER_W'($urandom_range(0, 1000));
            8:    return {NUMBER_W{1'b1}} - $urandom_range(0, 1000);
            default: return full & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
    endfunction

    // mostly short gaps, a few long ones, and stretches of back-to-back words
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            burst_left = $urandom_range(4, 16);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    task automatic send_number(input logic [NUMBER_W-1:0] value);
        int gap;
        start  <= 1'b1;
        number <= value;
        do
            @(negedge clk);
        while (!taken);
        gap = pick_gap();
        if (gap > 0)
        begin
            start  <= 1'b0;
            number <= {$urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
    endtask

    logic [NUMBER_W-1:0] corner_numbers [20];

    initial
    begin
        start      = 1'b0;
        number     = '0;
        rst_n      = 1'b0;
        burst_left = 0;
        corner_numbers = '{
            64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100,
            64'd1000000000, 64'd9999999999, 64'd4294967295, 64'd4294967296,
            64'd9999999999999999999, 64'd10000000000000000000,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h0123_4567_89AB_CDEF
        };
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (corner_numbers[i])
            send_number(corner_numbers[i]);
        for (int i = 0; i < RANDOM_NUMBERS; i++)
            send_number(random_number());
        start <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("converted %0d numbers into %0d characters", numbers_seen, chars_seen);
        $display("run lengths seen: %0d of 20 possible", $countones(lengths_seen));
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== unsigned_to_decimal_ascii_top.f =====
design/utda_pkg.sv
design/utda_digit_cell.sv
design/unsigned_to_decimal_ascii_top.sv
tb/utda_checker.sv
tb/tb_unsigned_to_decimal_ascii_top.sv
